/* sv/four_state_operator_alu_defines.svh */
// Assertion macros for the four-state operator ALU.
// Used by the modules that carry concurrent checks.
`ifndef FOUR_STATE_OPERATOR_ALU_DEFINES_SVH
`define FOUR_STATE_OPERATOR_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define FSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FSA_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FSA_ASSERT(label, clk, rst_n, prop)
`define FSA_ASSERT_RST(label, clk, prop)
`endif
`endif

/* sv/fsalu_pkg.sv */
// Package for the four-state operator ALU: payload structs, command codes,
// controller states and the control and status structs. No dependencies.
package fsalu_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int WIDTH_BITS = 7;
    localparam int COUNT_BITS = 6;

    typedef enum logic [5:0] {
        CMD_ADD = 6'd0, CMD_SUB = 6'd1, CMD_MUL = 6'd2, CMD_DIV = 6'd3,
        CMD_MOD = 6'd4, CMD_POW = 6'd5, CMD_AND = 6'd6, CMD_OR = 6'd7,
        CMD_XOR = 6'd8, CMD_SHL = 6'd9, CMD_ASHL = 6'd10, CMD_SHR = 6'd11,
        CMD_ASHR = 6'd12, CMD_EQ = 6'd13, CMD_CEQ = 6'd14, CMD_NE = 6'd15,
        CMD_CNE = 6'd16, CMD_WEQ = 6'd17, CMD_WNE = 6'd18, CMD_LT = 6'd19,
        CMD_GT = 6'd20, CMD_LE = 6'd21, CMD_GE = 6'd22, CMD_LAND = 6'd23,
        CMD_LOR = 6'd24, CMD_RAND = 6'd25, CMD_ROR = 6'd26, CMD_RXOR = 6'd27,
        CMD_RNAND = 6'd28, CMD_RNOR = 6'd29, CMD_RXNOR = 6'd30,
        CMD_NOT = 6'd31, CMD_LNOT = 6'd32, CMD_NEG = 6'd33
    } cmd_t;

    typedef struct packed {
        logic [5:0]            command;
        logic [DATA_WIDTH-1:0] lhs_value;
        logic [DATA_WIDTH-1:0] lhs_unknown;
        logic [WIDTH_BITS-1:0] lhs_width;
        logic                  lhs_signed;
        logic [DATA_WIDTH-1:0] rhs_value;
        logic [DATA_WIDTH-1:0] rhs_unknown;
        logic [WIDTH_BITS-1:0] rhs_width;
    } in_word_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result_value;
        logic [DATA_WIDTH-1:0] result_unknown;
        logic [WIDTH_BITS-1:0] result_width;
        logic                  result_signed;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_ITER, ST_MULT, ST_DONE
    } state_t;

    // Iterative operation kinds run on the shared unit.
    typedef enum logic [1:0] {
        IT_NONE, IT_MUL, IT_DIV, IT_POW
    } iter_t;

    typedef struct packed {
        logic  load;     // capture operands
        logic  prep;     // normalize and set up the unit
        logic  step;     // one iteration step
        logic  mstep;    // one partial-product step
        logic  finish;   // form the result word
    } ctrl_t;

    typedef struct packed {
        iter_t kind;
        logic  last;     // iteration counter at final step
        logic  mlast;    // last partial product of a multiply
        logic  mneed;    // current step needs a multiply
    } stat_t;

endpackage

/* sv/fsalu_ctrl.sv */
// Controller state machine for the four-state operator ALU.
// Depends on fsalu_pkg and the assertion macro header.
`include "four_state_operator_alu_defines.svh"
module fsalu_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  fsalu_pkg::stat_t   stat,
    output fsalu_pkg::ctrl_t   ctrl,
    output logic               busy,
    output logic               done
);

    fsalu_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsalu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            fsalu_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load = 1'b1;
                    state_next = fsalu_pkg::ST_PREP;
                end
            end
            fsalu_pkg::ST_PREP:
            begin
                ctrl.prep = 1'b1;
                state_next = (stat.kind == fsalu_pkg::IT_NONE) ? fsalu_pkg::ST_DONE
                                                                : fsalu_pkg::ST_ITER;
            end
            fsalu_pkg::ST_ITER:
            begin
                if (stat.mneed)
                begin
                    state_next = fsalu_pkg::ST_MULT;
                end
                else
                begin
                    ctrl.step = 1'b1;
                    if (stat.last)
                    begin
                        state_next = fsalu_pkg::ST_DONE;
                    end
                end
            end
            fsalu_pkg::ST_MULT:
            begin
                ctrl.mstep = 1'b1;
                if (stat.mlast)
                begin
                    state_next = fsalu_pkg::ST_ITER;
                end
            end
            fsalu_pkg::ST_DONE:
            begin
                ctrl.finish = 1'b1;
                done = 1'b1;
                state_next = fsalu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fsalu_pkg::ST_IDLE;
            end
        endcase
    end

    `FSA_ASSERT(a_done_after_busy, clk, rst_n, done |-> $past(busy))
    `FSA_ASSERT(a_idle_after_done, clk, rst_n, done |=> !busy)
    `FSA_ASSERT(a_load_starts, clk, rst_n, ctrl.load |=> (state_reg == fsalu_pkg::ST_PREP))

endmodule

/* sv/fsalu_dp.sv */
// Datapath of the four-state operator ALU: operand capture, the combinational
// operators and a shared shift/add unit for multiply, divide and power.
// Depends on fsalu_pkg.
module fsalu_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsalu_pkg::in_word_t  in_word,
    input  fsalu_pkg::ctrl_t     ctrl,
    output fsalu_pkg::stat_t     stat,
    output fsalu_pkg::out_word_t out_word
);

    localparam int DW = fsalu_pkg::DATA_WIDTH;
    localparam int WB = fsalu_pkg::WIDTH_BITS;
    localparam int CB = fsalu_pkg::COUNT_BITS;

    fsalu_pkg::in_word_t in_reg;
    logic [DW-1:0] lv_reg, lu_reg, rv_reg, ru_reg, lm_reg, mm_reg;
    logic [WB-1:0] lw_reg, rw_reg, mw_reg;
    fsalu_pkg::iter_t kind_reg;
    logic [CB-1:0] cnt_reg;
    // Iteration registers: acc holds product/quotient/power result,
    // rem holds remainder, opb holds multiplicand/base, ex holds multiplier/exponent bits.
    logic [DW-1:0] acc_reg, rem_reg, opb_reg, ex_reg;
    // Multiply unit for power: 64x64 low product in four 64x16 steps.
    logic [DW-1:0] ma_reg, mb_reg, mp_reg;
    logic [1:0]    mcnt_reg;
    logic          msel_reg;  // 0: r*=b, 1: b*=b
    logic          mdone_reg;

    // Width clamp and mask.
    function automatic logic [WB-1:0] clampw(input logic [WB-1:0] w);
        if (w == '0)
        begin
            return WB'(1);
        end
        else if (w > WB'(DW))
        begin
            return WB'(DW);
        end
        return w;
    endfunction

    function automatic logic [DW-1:0] wmask(input logic [WB-1:0] w);
        logic [DW-1:0] m;
        m = '1;
        if (w < WB'(DW))
        begin
            m = ~({DW{1'b1}} << w[CB-1:0]);
        end
        return m;
    endfunction

    logic [WB-1:0] lwc, rwc;
    assign lwc = clampw(in_word.lhs_width);
    assign rwc = clampw(in_word.rhs_width);

    fsalu_pkg::cmd_t cmd;
    assign cmd = fsalu_pkg::cmd_t'(in_reg.command);

    // Restoring divide step.
    logic [DW:0]   dtrial;
    logic [DW:0]   dshift;
    assign dshift = {rem_reg, acc_reg[DW-1]};
    assign dtrial = dshift - {1'b0, rv_reg};

    // Partial product: 64 x 16 slice, summed into the low 64 bits.
    logic [15:0]   mslice;
    logic [DW-1:0] mpart;
    assign mslice = mb_reg[16*mcnt_reg +: 16];
    assign mpart  = DW'(ma_reg * mslice) << (16 * mcnt_reg);

    assign stat.kind  = kind_reg;
    assign stat.last  = (cnt_reg == CB'(DW-1));
    assign stat.mlast = (mcnt_reg == 2'd3);
    assign stat.mneed = (kind_reg == fsalu_pkg::IT_POW) && !mdone_reg;

    // Combinational result forming.
    logic [DW-1:0] val, unk;
    logic [WB-1:0] rwid;
    logic          sgn;
    logic [DW-1:0] l1, r1, l0, r0, one, zero, known, inv;
    logic          caseq, wild, big;
    logic [CB-1:0] sh;
    logic [CB-1:0] ltop;

    always_comb
    begin
        l1 = lv_reg & ~lu_reg;
        r1 = rv_reg & ~ru_reg;
        l0 = ~lv_reg & ~lu_reg;
        r0 = ~rv_reg & ~ru_reg;
        known = ~lu_reg & ~ru_reg;
        one = '0;
        zero = '0;
        inv = ~(lv_reg | ~lm_reg);
        big = (rv_reg >= DW'(DW));
        sh = rv_reg[CB-1:0];
        ltop = CB'(lw_reg - WB'(1));
        caseq = (lw_reg == rw_reg) && (lv_reg == rv_reg) && (lu_reg == ru_reg);
        wild = ((lv_reg ^ rv_reg) & ~ru_reg) == '0;
        val = '0;
        unk = '0;
        rwid = WB'(1);
        sgn = 1'b0;
        unique case (cmd)
            fsalu_pkg::CMD_ADD: begin val = (lv_reg + rv_reg) & mm_reg; rwid = mw_reg; end
            fsalu_pkg::CMD_SUB: begin val = (lv_reg - rv_reg) & mm_reg; rwid = mw_reg; end
            fsalu_pkg::CMD_MUL, fsalu_pkg::CMD_DIV, fsalu_pkg::CMD_POW:
            begin
                val = (rv_reg == '0 && cmd == fsalu_pkg::CMD_DIV) ? '0 : acc_reg & mm_reg;
                rwid = mw_reg;
            end
            fsalu_pkg::CMD_MOD:
            begin
                val = (rv_reg == '0) ? '0 : rem_reg & mm_reg;
                rwid = mw_reg;
            end
            fsalu_pkg::CMD_AND, fsalu_pkg::CMD_OR, fsalu_pkg::CMD_XOR:
            begin
                if (cmd == fsalu_pkg::CMD_AND)
                begin
                    one = l1 & r1;
                    zero = l0 | r0;
                end
                else if (cmd == fsalu_pkg::CMD_OR)
                begin
                    one = l1 | r1;
                    zero = l0 & r0;
                end
                else
                begin
                    one = (lv_reg ^ rv_reg) & known;
                    zero = ~(lv_reg ^ rv_reg) & known;
                end
                unk = ~(one | zero) & mm_reg;
                val = (one | unk) & mm_reg;
                rwid = mw_reg;
            end
            fsalu_pkg::CMD_SHL, fsalu_pkg::CMD_ASHL, fsalu_pkg::CMD_SHR,
            fsalu_pkg::CMD_ASHR:
            begin
                rwid = lw_reg;
                sgn = in_reg.lhs_signed;
                if (cmd == fsalu_pkg::CMD_SHL || cmd == fsalu_pkg::CMD_ASHL)
                begin
                    val = big ? '0 : (lv_reg << sh);
                end
                else if (cmd == fsalu_pkg::CMD_SHR || !lv_reg[ltop])
                begin
                    val = big ? '0 : (lv_reg >> sh);
                end
                else
                begin
                    val = big ? '1 : ~(inv >> sh);
                end
                val = val & lm_reg;
            end
            fsalu_pkg::CMD_EQ:   val = DW'(lv_reg == rv_reg);
            fsalu_pkg::CMD_CEQ:  val = DW'(caseq);
            fsalu_pkg::CMD_NE:   val = DW'(lv_reg != rv_reg);
            fsalu_pkg::CMD_CNE:  val = DW'(!caseq);
            fsalu_pkg::CMD_WEQ:  val = DW'(wild);
            fsalu_pkg::CMD_WNE:  val = DW'(!wild);
            fsalu_pkg::CMD_LT:   val = DW'(lv_reg < rv_reg);
            fsalu_pkg::CMD_GT:   val = DW'(lv_reg > rv_reg);
            fsalu_pkg::CMD_LE:   val = DW'(lv_reg <= rv_reg);
            fsalu_pkg::CMD_GE:   val = DW'(lv_reg >= rv_reg);
            fsalu_pkg::CMD_LAND: val = DW'(lv_reg != '0 && rv_reg != '0);
            fsalu_pkg::CMD_LOR:  val = DW'(lv_reg != '0 || rv_reg != '0);
            fsalu_pkg::CMD_RAND: val = DW'(lv_reg == lm_reg);
            fsalu_pkg::CMD_ROR:  val = DW'(lv_reg != '0);
            fsalu_pkg::CMD_RXOR: val = DW'(^lv_reg);
            fsalu_pkg::CMD_RNAND: val = DW'(lv_reg != lm_reg);
            fsalu_pkg::CMD_RNOR: val = DW'(lv_reg == '0);
            fsalu_pkg::CMD_RXNOR: val = DW'(~^lv_reg);
            fsalu_pkg::CMD_NOT:
            begin
                rwid = lw_reg;
                unk = lu_reg;
                val = (~lv_reg | lu_reg) & lm_reg;
            end
            fsalu_pkg::CMD_LNOT: val = DW'(lv_reg == '0);
            fsalu_pkg::CMD_NEG:
            begin
                rwid = lw_reg;
                val = (DW'(0) - lv_reg) & lm_reg;
            end
            default:
            begin
                val = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= fsalu_pkg::IT_NONE;
            cnt_reg <= '0;
            mcnt_reg <= '0;
            mdone_reg <= 1'b0;
            msel_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                priority case (in_word.command)
                    fsalu_pkg::CMD_MUL: kind_reg <= fsalu_pkg::IT_MUL;
                    fsalu_pkg::CMD_DIV, fsalu_pkg::CMD_MOD: kind_reg <= fsalu_pkg::IT_DIV;
                    fsalu_pkg::CMD_POW: kind_reg <= fsalu_pkg::IT_POW;
                    default: kind_reg <= fsalu_pkg::IT_NONE;
                endcase
            end
            if (ctrl.prep)
            begin
                cnt_reg <= '0;
                mcnt_reg <= '0;
                mdone_reg <= 1'b0;
                msel_reg <= 1'b0;
            end
            if (ctrl.step)
            begin
                cnt_reg <= cnt_reg + CB'(1);
                mdone_reg <= 1'b0;
                msel_reg <= 1'b0;
            end
            if (ctrl.mstep)
            begin
                mcnt_reg <= mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    // Two multiplies per power step: r*=b, then b*=b.
                    msel_reg <= !msel_reg;
                    mdone_reg <= msel_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            in_reg <= in_word;
            lw_reg <= lwc;
            rw_reg <= rwc;
            mw_reg <= (lwc > rwc) ? lwc : rwc;
            lm_reg <= wmask(lwc);
            mm_reg <= wmask((lwc > rwc) ? lwc : rwc);
            lv_reg <= in_word.lhs_value & wmask(lwc);
            lu_reg <= in_word.lhs_unknown & wmask(lwc);
            rv_reg <= in_word.rhs_value & wmask(rwc);
            ru_reg <= in_word.rhs_unknown & wmask(rwc);
        end
        if (ctrl.prep)
        begin
            unique case (kind_reg)
                fsalu_pkg::IT_MUL:
                begin
                    acc_reg <= '0;
                    opb_reg <= lv_reg;
                    ex_reg <= rv_reg;
                end
                fsalu_pkg::IT_DIV:
                begin
                    acc_reg <= lv_reg;
                    rem_reg <= '0;
                end
                fsalu_pkg::IT_POW:
                begin
                    acc_reg <= DW'(1);
                    opb_reg <= lv_reg;
                    ex_reg <= rv_reg;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
        if (ctrl.step)
        begin
            unique case (kind_reg)
                fsalu_pkg::IT_MUL:
                begin
                    // Shift-add: one multiplier bit per step.
                    if (ex_reg[0])
                    begin
                        acc_reg <= acc_reg + opb_reg;
                    end
                    opb_reg <= opb_reg << 1;
                    ex_reg <= ex_reg >> 1;
                end
                fsalu_pkg::IT_DIV:
                begin
                    acc_reg <= {acc_reg[DW-2:0], !dtrial[DW]};
                    rem_reg <= dtrial[DW] ? dshift[DW-1:0] : dtrial[DW-1:0];
                end
                fsalu_pkg::IT_POW:
                begin
                    ex_reg <= ex_reg >> 1;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
        if (ctrl.mstep)
        begin
            if (mcnt_reg == 2'd0)
            begin
                mp_reg <= mpart;
            end
            else
            begin
                mp_reg <= mp_reg + mpart;
            end
            if (mcnt_reg == 2'd3)
            begin
                if (!msel_reg)
                begin
                    if (ex_reg[0])
                    begin
                        acc_reg <= mp_reg + mpart;
                    end
                end
                else
                begin
                    opb_reg <= mp_reg + mpart;
                end
            end
        end
        // Operand select for the multiply unit, set ahead of each pass.
        if (ctrl.step || ctrl.prep || (ctrl.mstep && mcnt_reg == 2'd3))
        begin
            ma_reg <= opb_reg;
            mb_reg <= opb_reg;
        end
        if (!ctrl.mstep && !msel_reg)
        begin
            ma_reg <= opb_reg;
            mb_reg <= acc_reg;
        end
    end

    // The result word is formed from settled operand and iteration registers
    // and is driven only in the finish cycle, the cycle that done marks.
    assign out_word.result_value   = ctrl.finish ? val : '0;
    assign out_word.result_unknown = ctrl.finish ? unk : '0;
    assign out_word.result_width   = ctrl.finish ? rwid : '0;
    assign out_word.result_signed  = ctrl.finish ? sgn : 1'b0;

endmodule

/* sv/four_state_operator_alu.sv */
// Top level of the four-state operator ALU.
// Depends on fsalu_pkg, fsalu_ctrl, fsalu_dp and the assertion macro header.
// Usage: raise start with a command word while busy is low; the word is taken at
// that clock edge and busy rises. The result word appears on result for exactly
// one cycle, marked by done, and must be captured then: the receiver cannot stall
// the block. Operators without iteration pass through a setup state and then the
// result state that raises done. Multiply and divide/modulo add 64 steps on the
// shared shift/add unit between them. Power always runs 64 exponent steps, each
// building two 64-bit low products from four 16-bit partial products and then
// shifting the exponent. Busy falls in the cycle after done, and the next word
// can be accepted at the end of that cycle.
`include "four_state_operator_alu_defines.svh"
module four_state_operator_alu
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fsalu_pkg::in_word_t  operands,
    output logic                 busy,
    output logic                 done,
    output fsalu_pkg::out_word_t result
);

    fsalu_pkg::ctrl_t ctrl;
    fsalu_pkg::stat_t stat;

    fsalu_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    fsalu_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (operands),
        .ctrl     (ctrl),
        .stat     (stat),
        .out_word (result)
    );

    `FSA_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
    `FSA_ASSERT(a_done_busy, clk, rst_n, done |-> busy)
    `FSA_ASSERT_RST(a_reset_idle, clk, !rst_n |-> !busy)

endmodule
